### sv/gte_pkg.sv
// Shared types and constants of the graph traversal engine.
// Holds the operation codes, controller states and the command/status bundles.
// No dependencies; every other file but gte_ram imports this package.
`default_nettype none

package gte_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int VERTEX_W         = 5;
  localparam int OP_W             = 2;
  localparam int COUNT_W          = 6;
  localparam int IN_TDATA_W       = 16;
  localparam int OUT_TDATA_W      = 8;

  localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(32);

  typedef enum logic [OP_W-1:0] {
    OP_ADD_EDGE = 2'd0,
    OP_DFS      = 2'd1,
    OP_BFS      = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ADD_RD_A,
    ST_ADD_WR_A,
    ST_ADD_RD_B,
    ST_ADD_WR_B,
    ST_DFS_INIT,
    ST_DFS_ROW,
    ST_DFS_POP,
    ST_BFS_INIT,
    ST_BFS_DEQ,
    ST_BFS_VTX,
    ST_BFS_SCAN,
    ST_FLUSH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // latch the accepted request
    logic clear_rows;  // drop every adjacency row
    logic rd_row_a;
    logic wr_row_a;
    logic rd_row_b;
    logic wr_row_b;
    logic dfs_init;
    logic dfs_push;
    logic dfs_pop;
    logic rd_row_top;
    logic bfs_init;
    logic bfs_deq;
    logic bfs_emit;
    logic bfs_enq;
    logic flush;       // send the held vertex as the final one
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic a_ok;
    logic b_ok;
    logic cand_any;
    logic sp_one;
    logic q_empty;
    logic slot_free;
    logic emit_ok;
  } sts_t;

endpackage

`default_nettype wire

### sv/gte_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the adjacency rows, the walk stack and the walk queue.
`default_nettype none

module gte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### sv/gte_ctrl.sv
// Sequencing state machine of the graph traversal engine.
// Depends on gte_pkg; drives gte_dp through cmd_t and reads sts_t.
`default_nettype none

module gte_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output gte_pkg::cmd_t cmd,
  input  gte_pkg::sts_t sts
);

  import gte_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        if (sts.op == OP_CLEAR || !sts.a_ok) begin
          state_nxt = ST_IDLE;
        end else begin
          case (sts.op)
            OP_ADD_EDGE: state_nxt = sts.b_ok ? ST_ADD_RD_A : ST_IDLE;
            OP_DFS:      state_nxt = ST_DFS_INIT;
            OP_BFS:      state_nxt = ST_BFS_INIT;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD_RD_A: state_nxt = ST_ADD_WR_A;
      ST_ADD_WR_A: state_nxt = ST_ADD_RD_B;
      ST_ADD_RD_B: state_nxt = ST_ADD_WR_B;
      ST_ADD_WR_B: state_nxt = ST_IDLE;
      ST_DFS_INIT: state_nxt = ST_DFS_ROW;
      ST_DFS_ROW: begin
        if (!sts.cand_any) state_nxt = sts.sp_one ? ST_FLUSH : ST_DFS_POP;
      end
      ST_DFS_POP:  state_nxt = ST_DFS_ROW;
      ST_BFS_INIT: state_nxt = ST_BFS_DEQ;
      ST_BFS_DEQ:  state_nxt = sts.q_empty ? ST_FLUSH : ST_BFS_VTX;
      ST_BFS_VTX: begin
        if (sts.emit_ok) state_nxt = ST_BFS_SCAN;
      end
      ST_BFS_SCAN: begin
        if (!sts.cand_any) state_nxt = ST_BFS_DEQ;
      end
      ST_FLUSH: begin
        if (sts.slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE:     cmd.load = in_tvalid;
      ST_DECODE:   cmd.clear_rows = (sts.op == OP_CLEAR);
      ST_ADD_RD_A: cmd.rd_row_a = 1'b1;
      ST_ADD_WR_A: cmd.wr_row_a = 1'b1;
      ST_ADD_RD_B: cmd.rd_row_b = 1'b1;
      ST_ADD_WR_B: cmd.wr_row_b = 1'b1;
      ST_DFS_INIT: cmd.dfs_init = 1'b1;
      ST_DFS_ROW: begin
        cmd.dfs_push = sts.cand_any & sts.emit_ok;
        cmd.dfs_pop  = ~sts.cand_any;
      end
      ST_DFS_POP:  cmd.rd_row_top = 1'b1;
      ST_BFS_INIT: cmd.bfs_init = 1'b1;
      ST_BFS_DEQ:  cmd.bfs_deq = ~sts.q_empty;
      ST_BFS_VTX:  cmd.bfs_emit = sts.emit_ok;
      ST_BFS_SCAN: cmd.bfs_enq = sts.cand_any;
      ST_FLUSH:    cmd.flush = sts.slot_free;
      default:     cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

### sv/gte_dp.sv
// Datapath of the graph traversal engine: adjacency rows, visited bits,
// walk stack and queue, neighbour pick and output register.
// Depends on gte_pkg and gte_ram; steered by gte_ctrl.
`default_nettype none

module gte_dp #(
  parameter int MAX_V = gte_pkg::MAX_VERTICES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [gte_pkg::COUNT_W-1:0]   cfg_wr_data,
  input  logic [gte_pkg::OP_W-1:0]      in_op,
  input  logic [gte_pkg::VERTEX_W-1:0]  in_a,
  input  logic [gte_pkg::VERTEX_W-1:0]  in_b,
  input  gte_pkg::cmd_t                 cmd,
  output gte_pkg::sts_t                 sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gte_pkg::VERTEX_W-1:0]  out_vertex,
  output logic                          out_last
);

  import gte_pkg::*;

  localparam int VW   = (MAX_V > 1) ? $clog2(MAX_V) : 1;
  localparam int NW   = $clog2(MAX_V + 1);
  localparam int CMPW = (NW > COUNT_W) ? NW : COUNT_W;
  localparam int PW   = VW + 1;

  logic [COUNT_W-1:0] vc_r;
  logic [NW-1:0]      n_eff;
  logic [NW-1:0]      n_r;
  op_t                op_r;
  logic [VW-1:0]      a_r, b_r;
  logic               a_ok_r, b_ok_r;

  logic [MAX_V-1:0]   row_vld_r;
  logic               rd_vld_r;
  logic [MAX_V-1:0]   visited_r;
  logic [PW-1:0]      sp_r, head_r, tail_r;
  logic [PW-1:0]      stk_rd_ptr;

  logic [VW-1:0]      pend_r;
  logic               pend_vld_r;
  logic               out_vld_r;
  logic [VERTEX_W-1:0] out_vtx_r;
  logic               out_last_r;

  logic [MAX_V-1:0]   row_rdata, row, live, cand;
  logic [MAX_V-1:0]   a_hot, b_hot, j_hot;
  logic [VW-1:0]      j_sel;
  logic               row_rd_en, row_wr_en;
  logic [VW-1:0]      row_rd_addr, row_wr_addr;
  logic [MAX_V-1:0]   row_wr_data;
  logic [VW-1:0]      stk_rdata, q_rdata;
  logic               emit_en, slot_free, out_load;
  logic [VW-1:0]      emit_vtx;

  // Clamp the configured count to the capacity
  assign n_eff = (CMPW'(vc_r) > CMPW'(MAX_V)) ? NW'(MAX_V) : NW'(vc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= COUNT_RST;
    end else if (cfg_wr_en) begin
      vc_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(in_op);
      a_r    <= VW'(in_a);
      b_r    <= VW'(in_b);
      a_ok_r <= (CMPW'(in_a) < CMPW'(n_eff));
      b_ok_r <= (CMPW'(in_b) < CMPW'(n_eff));
      n_r    <= n_eff;
    end
  end

  for (genvar gj = 0; gj < MAX_V; gj++) begin : g_live
    assign live[gj] = (CMPW'(gj) < CMPW'(n_r));
  end

  assign a_hot = MAX_V'(1) << a_r;
  assign b_hot = MAX_V'(1) << b_r;
  assign row   = rd_vld_r ? row_rdata : '0;
  assign cand  = row & live & ~visited_r;

  // Lowest unvisited neighbour
  always_comb begin
    j_sel = '0;
    for (int i = MAX_V - 1; i >= 0; i--) begin
      if (cand[i]) j_sel = VW'(i);
    end
  end
  assign j_hot = MAX_V'(1) << j_sel;

  // Adjacency row port steering
  always_comb begin
    row_rd_en = cmd.rd_row_a | cmd.rd_row_b | cmd.dfs_init | cmd.dfs_push |
                cmd.rd_row_top | cmd.bfs_emit;
    if (cmd.rd_row_b) begin
      row_rd_addr = b_r;
    end else if (cmd.dfs_push) begin
      row_rd_addr = j_sel;
    end else if (cmd.rd_row_top) begin
      row_rd_addr = stk_rdata;
    end else if (cmd.bfs_emit) begin
      row_rd_addr = q_rdata;
    end else begin
      row_rd_addr = a_r;
    end
    row_wr_en   = cmd.wr_row_a | cmd.wr_row_b;
    row_wr_addr = cmd.wr_row_b ? b_r : a_r;
    row_wr_data = row | (cmd.wr_row_b ? a_hot : b_hot);
  end

  gte_ram #(.WIDTH(MAX_V), .DEPTH(MAX_V)) u_rows (
    .clk     (clk),
    .wr_en   (row_wr_en),
    .wr_addr (row_wr_addr),
    .wr_data (row_wr_data),
    .rd_en   (row_rd_en),
    .rd_addr (row_rd_addr),
    .rd_data (row_rdata)
  );

  // A row that is not valid reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_rows) begin
      row_vld_r <= '0;
    end else if (row_wr_en) begin
      row_vld_r[row_wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (row_rd_en) begin
      rd_vld_r <= row_vld_r[row_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visited_r <= '0;
    end else if (cmd.dfs_init || cmd.bfs_init) begin
      visited_r <= a_hot;
    end else if (cmd.dfs_push || cmd.bfs_enq) begin
      visited_r <= visited_r | j_hot;
    end
  end

  // Stack and queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r   <= '0;
      head_r <= '0;
      tail_r <= '0;
    end else begin
      if (cmd.dfs_init) begin
        sp_r <= PW'(1);
      end else if (cmd.dfs_push) begin
        sp_r <= sp_r + PW'(1);
      end else if (cmd.dfs_pop) begin
        sp_r <= sp_r - PW'(1);
      end
      if (cmd.bfs_init) begin
        head_r <= '0;
        tail_r <= PW'(1);
      end else begin
        if (cmd.bfs_deq) head_r <= head_r + PW'(1);
        if (cmd.bfs_enq) tail_r <= tail_r + PW'(1);
      end
    end
  end

  assign stk_rd_ptr = sp_r - PW'(2);

  gte_ram #(.WIDTH(VW), .DEPTH(MAX_V)) u_stack (
    .clk     (clk),
    .wr_en   (cmd.dfs_init | cmd.dfs_push),
    .wr_addr (cmd.dfs_push ? sp_r[VW-1:0] : VW'(0)),
    .wr_data (cmd.dfs_push ? j_sel : a_r),
    .rd_en   (cmd.dfs_pop),
    .rd_addr (stk_rd_ptr[VW-1:0]),
    .rd_data (stk_rdata)
  );

  gte_ram #(.WIDTH(VW), .DEPTH(MAX_V)) u_queue (
    .clk     (clk),
    .wr_en   (cmd.bfs_init | cmd.bfs_enq),
    .wr_addr (cmd.bfs_enq ? tail_r[VW-1:0] : VW'(0)),
    .wr_data (cmd.bfs_enq ? j_sel : a_r),
    .rd_en   (cmd.bfs_deq),
    .rd_addr (head_r[VW-1:0]),
    .rd_data (q_rdata)
  );

  // Hold one vertex back so that the final one can carry last
  assign emit_en   = cmd.dfs_init | cmd.dfs_push | cmd.bfs_emit;
  assign emit_vtx  = cmd.dfs_push ? j_sel : (cmd.bfs_emit ? q_rdata : a_r);
  assign slot_free = ~out_vld_r | out_ready;
  assign out_load  = cmd.flush | (emit_en & pend_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (emit_en) begin
        pend_vld_r <= 1'b1;
      end else if (cmd.flush) begin
        pend_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_vtx_r  <= VERTEX_W'(pend_r);
      out_last_r <= cmd.flush;
    end
    if (emit_en) begin
      pend_r <= emit_vtx;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_vertex = out_vtx_r;
  assign out_last   = out_last_r;

  always_comb begin
    sts           = '0;
    sts.op        = op_r;
    sts.a_ok      = a_ok_r;
    sts.b_ok      = b_ok_r;
    sts.cand_any  = |cand;
    sts.sp_one    = (sp_r == PW'(1));
    sts.q_empty   = (head_r == tail_r);
    sts.slot_free = slot_free;
    sts.emit_ok   = ~pend_vld_r | slot_free;
  end

endmodule

`default_nettype wire

### sv/graph_traversal_engine_core.sv
// Top level of the graph traversal engine.
// Depends on gte_pkg, gte_ctrl, gte_dp (and gte_ram through gte_dp).
//
//  Channel  | Direction | Handshake             | Payload
//  ---------+-----------+-----------------------+----------------------------------
//  in_      | slave     | in_tvalid / in_tready | tuser: operation; tdata: vertices
//  out_     | master    | out_tvalid/out_tready | tdata: visited_vertex; tlast: last
//  cfg_     | write     | cfg_wr_en             | cfg_wr_data: vertex_count
//
// One request at a time: in_tready is high only while the controller idles.
// Clear is done in the decode state; add edge reads and writes the row of
// vertex_a, then that of vertex_b. Every walk step first fetches one adjacency
// row through the single read port, and a depth-first step either pushes the
// next vertex or pops the stack.
// Reset (rst_n low, synchronous) empties the graph, drops any pending result
// and sets vertex_count to 32. A stalled out_tready freezes the walk at its
// next emission; the output register and one held-back vertex absorb the rest.
`default_nettype none

module graph_traversal_engine_core #(
  parameter int MAX_VERTICES = gte_pkg::MAX_VERTICES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration: vertex_count
  input  logic                              cfg_wr_en,
  input  logic [gte_pkg::COUNT_W-1:0]       cfg_wr_data,
  // Request channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [gte_pkg::IN_TDATA_W-1:0]    in_tdata,  // [4:0] vertex_a, [9:5] vertex_b
  input  logic [gte_pkg::OP_W-1:0]          in_tuser,  // [1:0] operation
  // Result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [gte_pkg::OUT_TDATA_W-1:0]   out_tdata, // [4:0] visited_vertex
  output logic                              out_tlast  // last vertex of the walk
);

  import gte_pkg::*;

  cmd_t                cmd;
  sts_t                sts;
  logic [VERTEX_W-1:0] out_vertex;

  // Sequencer: decodes the request and steps the walk
  gte_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Storage and the neighbour pick
  gte_dp #(.MAX_V(MAX_VERTICES)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_op       (in_tuser),
    .in_a        (in_tdata[VERTEX_W-1:0]),
    .in_b        (in_tdata[2*VERTEX_W-1:VERTEX_W]),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_vertex  (out_vertex),
    .out_last    (out_tlast)
  );

  // Pad the vertex number to a whole byte
  assign out_tdata = OUT_TDATA_W'(out_vertex);

endmodule

`default_nettype wire

### tb/sv/graph_traversal_engine_core_tb.sv
// Self-checking testbench for graph_traversal_engine_core: drives edge, walk and clear
// requests, predicts the visit order of each walk and checks every result beat.
// Depends on gte_pkg and the RTL of the engine; needs no files or arguments.
`default_nettype none

module graph_traversal_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gte_pkg::*;

  localparam int CAPACITY      = MAX_VERTICES_DEF;
  localparam int SETTLE_CYCLES = 16;    // time for an add edge or a final flush to finish
  localparam int END_CYCLES    = 40;
  localparam int QUIET_LIMIT   = 4000;  // cycles with no handshake on either channel
  localparam int RANDOM_ITEMS  = 95;
  localparam int DUE_DEPTH     = 128;   // ring of beats still due on the result channel

  // One expected beat on the result channel
  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic                last;
  } visit_t;

  // Predicts the walk output from its own copy of the matrix and holds the
  // beats that are still due on the result channel.
  class visit_order_scoreboard;
    logic [CAPACITY-1:0] rows [CAPACITY];
    logic [CAPACITY-1:0] visited;
    logic [COUNT_W-1:0]  vertex_count;
    int                  walk_order [CAPACITY];
    int                  walk_len;
    visit_t              due_visits [DUE_DEPTH];
    int                  due_head;
    int                  due_tail;
    int                  errors;

    function new();
      foreach (rows[i]) rows[i] = '0;
      visited      = '0;
      vertex_count = COUNT_RST;
      walk_len     = 0;
      due_head     = 0;
      due_tail     = 0;
      errors       = 0;
    endfunction

    function void set_count(logic [COUNT_W-1:0] value);
      vertex_count = value;
    endfunction

    function int pending();
      return due_tail - due_head;
    endfunction

    function void mark_visit(int v);
      walk_order[walk_len] = v;
      walk_len++;
      visited[v] = 1'b1;
    endfunction

    function void predict_depth_walk(int start, int n, logic [CAPACITY-1:0] live);
      int stack_vertex [CAPACITY];
      int stack_next [CAPACITY];
      int sp;
      int u;
      int j;
      logic [CAPACITY-1:0] cand;
      mark_visit(start);
      stack_vertex[0] = start;
      stack_next[0]   = 0;
      sp = 1;
      while (sp > 0) begin
        u    = stack_vertex[sp-1];
        j    = stack_next[sp-1];
        cand = rows[u] & live & ~visited;
        while (j < n && !cand[j]) j++;
        if (j < n && sp < CAPACITY) begin
          stack_next[sp-1] = j + 1;
          mark_visit(j);
          stack_vertex[sp] = j;
          stack_next[sp]   = 0;
          sp++;
        end else begin
          sp--;
        end
      end
    endfunction

    function void predict_breadth_walk(int start, int n, logic [CAPACITY-1:0] live);
      int fifo [CAPACITY];
      int head;
      int tail;
      int u;
      head = 0;
      tail = 0;
      visited[start] = 1'b1;
      fifo[tail] = start;
      tail++;
      while (head < tail) begin
        u = fifo[head];
        head++;
        mark_visit(u);
        for (int j = 0; j < n; j++) begin
          if (rows[u][j] && live[j] && !visited[j] && tail < CAPACITY) begin
            visited[j] = 1'b1;
            fifo[tail] = j;
            tail++;
          end
        end
      end
    endfunction

    function void note_request(op_t op, logic [VERTEX_W-1:0] a, logic [VERTEX_W-1:0] b);
      int n;
      logic [CAPACITY:0] wide;
      n    = (vertex_count > CAPACITY) ? CAPACITY : int'(vertex_count);
      wide = ((CAPACITY+1)'(1) << n) - 1;
      if (op == OP_CLEAR) begin
        foreach (rows[i]) rows[i] = '0;
        return;
      end
      if (int'(a) >= n) return;
      if (op == OP_ADD_EDGE) begin
        if (int'(b) >= n) return;
        rows[a][b] = 1'b1;
        rows[b][a] = 1'b1;
        return;
      end
      visited  = '0;
      walk_len = 0;
      if (op == OP_DFS) predict_depth_walk(a, n, wide[CAPACITY-1:0]);
      else predict_breadth_walk(a, n, wide[CAPACITY-1:0]);
      for (int i = 0; i < walk_len; i++) begin
        due_visits[due_tail % DUE_DEPTH].vertex = VERTEX_W'(walk_order[i]);
        due_visits[due_tail % DUE_DEPTH].last   = (i == walk_len - 1);
        due_tail++;
      end
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data, logic tlast);
      visit_t want;
      if (due_tail == due_head) begin
        errors++;
        $display("%0t ns: ERROR result with nothing due, expected none, got vertex %0d last %0b",
                 $time, data, tlast);
        return;
      end
      want = due_visits[due_head % DUE_DEPTH];
      due_head++;
      if (data !== OUT_TDATA_W'(want.vertex)) begin
        errors++;
        $display("%0t ns: ERROR visited_vertex expected %0d, got %0d",
                 $time, want.vertex, data);
      end
      if (tlast !== want.last) begin
        errors++;
        $display("%0t ns: ERROR last flag expected %0b, got %0b", $time, want.last, tlast);
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [COUNT_W-1:0]     cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [4:0] vertex_a, [9:5] vertex_b
  logic [OP_W-1:0]        in_tuser;   // [1:0] operation
  logic                   out_tvalid;
  logic                   out_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [4:0] visited_vertex
  logic                   out_tlast;

  visit_order_scoreboard visit_board = new();

  int burst_left  = 0;
  int quiet_count = 0;
  int stall_mode  = 0;
  int stall_tick  = 0;
  int stall_hold  = 0;

  graph_traversal_engine_core dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sample both channels at the rising edge; the flops of the block update
  // later in the same step, so these are the values that the edge captured.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) visit_board.check_result(out_tdata, out_tlast);
      if (in_tvalid && in_tready)
        visit_board.note_request(op_t'(in_tuser), in_tdata[4:0], in_tdata[9:5]);
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_count <= 0;
    end else if (quiet_count + 1 >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // Receiver back-pressure: periodically switch at random between four stall styles
  // (always ready, random stalls, a fixed duty pattern, long stretches).
  always @(negedge clk) begin
    stall_tick++;
    if (stall_tick % 50 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready = 1'b1;
      1: out_tready = ($urandom_range(0, 2) != 0);
      2: out_tready = ((stall_tick % 8) >= 3);
      default: begin
        if (stall_hold > 0) begin
          stall_hold--;
          out_tready = 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
          stall_hold = $urandom_range(4, 12);
          out_tready = 1'b0;
        end else begin
          out_tready = 1'b1;
        end
      end
    endcase
  end

  // Offer one request and hold it until the block takes it. The sender runs in
  // bursts; between bursts drop valid for a random gap, or for none at all.
  task automatic send_request(op_t op, logic [VERTEX_W-1:0] a, logic [VERTEX_W-1:0] b);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = IN_TDATA_W'({b, a});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
  endtask

  // Drop valid and wait until every predicted visit has come out.
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (visit_board.pending() != 0) @(posedge clk);
  endtask

  // Write vertex_count only once the block is idle; give an add edge that
  // gave no result time to finish first.
  task automatic write_count(logic [COUNT_W-1:0] value);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    visit_board.set_count(value);
  endtask

  initial begin
    int counted;
    int live;
    int roll;
    int phase_items;
    int phase;
    logic [COUNT_W-1:0] count_value;

    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: walks on an empty graph, duplicate and self-loop edges,
    // the top vertex, count lowered below existing edges, count above
    // capacity, count zero (only clear gets through) and a single vertex.
    send_request(OP_DFS, 0, 0);
    send_request(OP_BFS, 31, 31);
    send_request(OP_ADD_EDGE, 0, 31);
    send_request(OP_ADD_EDGE, 31, 0);
    send_request(OP_ADD_EDGE, 5, 5);
    send_request(OP_ADD_EDGE, 0, 1);
    send_request(OP_ADD_EDGE, 1, 2);
    send_request(OP_ADD_EDGE, 2, 31);
    send_request(OP_ADD_EDGE, 0, 16);
    send_request(OP_ADD_EDGE, 16, 10);
    send_request(OP_DFS, 0, 31);
    send_request(OP_BFS, 0, 0);
    send_request(OP_DFS, 31, 0);
    send_request(OP_BFS, 5, 0);
    write_count(6'd8);
    send_request(OP_DFS, 0, 0);
    send_request(OP_ADD_EDGE, 3, 9);
    send_request(OP_BFS, 9, 0);
    send_request(OP_ADD_EDGE, 7, 0);
    send_request(OP_BFS, 0, 0);
    write_count(6'd63);
    send_request(OP_DFS, 31, 0);
    write_count(6'd0);
    send_request(OP_ADD_EDGE, 0, 1);
    send_request(OP_DFS, 0, 0);
    send_request(OP_CLEAR, 0, 0);
    write_count(6'd1);
    send_request(OP_DFS, 0, 0);
    write_count(6'd32);
    send_request(OP_BFS, 2, 0);

    // Random phases: each picks a vertex count, then mostly in-range edges
    // and walks with the odd clear; a few noise requests with any fields.
    counted = 0;
    phase   = 0;
    while (counted < RANDOM_ITEMS) begin
      case (phase)
        0:       count_value = 6'd32;
        1:       count_value = 6'd1;
        2:       count_value = 6'd63;
        3:       count_value = 6'd2;
        default: count_value = COUNT_W'($urandom_range(1, 63));
      endcase
      write_count(count_value);
      live        = (count_value > CAPACITY) ? CAPACITY : int'(count_value);
      phase_items = $urandom_range(12, 25);
      for (int k = 0; k < phase_items && counted < RANDOM_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
          send_request(OP_ADD_EDGE, VERTEX_W'($urandom_range(0, live - 1)),
                       VERTEX_W'($urandom_range(0, live - 1)));
        end else if (roll < 90) begin
          send_request((roll < 70) ? OP_DFS : OP_BFS,
                       VERTEX_W'($urandom_range(0, live - 1)), VERTEX_W'($urandom()));
        end else if (roll < 94) begin
          send_request(OP_CLEAR, VERTEX_W'($urandom()), VERTEX_W'($urandom()));
        end else begin
          send_request(op_t'($urandom_range(0, 3)), VERTEX_W'($urandom()),
                       VERTEX_W'($urandom()));
        end
        counted++;
      end
      phase++;
    end

    drain();
    repeat (END_CYCLES) @(posedge clk);
    if (visit_board.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
sv/gte_pkg.sv
sv/gte_ram.sv
sv/gte_ctrl.sv
sv/gte_dp.sv
sv/graph_traversal_engine_core.sv
tb/sv/graph_traversal_engine_core_tb.sv
